// ===== hdl/mots_pkg.sv =====
package mots_pkg;

  localparam int DEFAULT_LIST_DEPTH = 1024;
  localparam int VAL_W = 32;
  localparam int MED_W = 33;
  localparam int OP_W = 2;
  localparam int STATUS_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND_FIRST  = 2'd0,
    OP_APPEND_SECOND = 2'd1,
    OP_MEDIAN        = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_CMP
  } search_state_t;

  // What the pair of reads issued in the evaluate step is used for.
  typedef enum logic [1:0] {
    M_TAIL,
    M_FIRST,
    M_PIVOT
  } search_mode_t;

  typedef struct packed {
    logic                    done;
    logic signed [MED_W-1:0] doubled;
  } search_res_t;

endpackage

// ===== hdl/mots_list_mem.sv =====
module mots_list_mem #(
  parameter int LIST_DEPTH = mots_pkg::DEFAULT_LIST_DEPTH,
  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1
) (
  input  logic                               clk,
  input  logic                               we,
  input  logic [AW-1:0]                      waddr,
  input  logic signed [mots_pkg::VAL_W-1:0]  wdata,
  input  logic [AW-1:0]                      raddr,
  output logic signed [mots_pkg::VAL_W-1:0]  rdata
);
  import mots_pkg::*;

  logic signed [VAL_W-1:0] mem [LIST_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read: data shows up in the cycle after the address.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/mots_search.sv =====
module mots_search #(
  parameter int LIST_DEPTH = mots_pkg::DEFAULT_LIST_DEPTH,
  localparam int CW = $clog2(LIST_DEPTH + 1),
  localparam int KW = CW + 1,
  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               go,
  input  logic [CW-1:0]                      count0,
  input  logic [CW-1:0]                      count1,
  output logic                               busy,
  output logic [AW-1:0]                      rd_addr0,
  output logic [AW-1:0]                      rd_addr1,
  input  logic signed [mots_pkg::VAL_W-1:0]  rd_data0,
  input  logic signed [mots_pkg::VAL_W-1:0]  rd_data1,
  output mots_pkg::search_res_t              res
);
  import mots_pkg::*;

  search_state_t           state_r, state_nxt;
  search_mode_t            mode_r, mode_nxt;
  logic                    asel_r, asel_nxt;
  logic [CW-1:0]           alo_r, alo_nxt, alen_r, alen_nxt;
  logic [CW-1:0]           blo_r, blo_nxt, blen_r, blen_nxt;
  logic [CW-1:0]           sa_r, sa_nxt;
  logic [KW-1:0]           sb_r, sb_nxt;
  logic [KW-1:0]           k_r, k_nxt, half_r, half_nxt;
  logic                    even_r, even_nxt, second_r, second_nxt;
  logic signed [VAL_W-1:0] upper_r, upper_nxt;

  // Evaluate step: range with the shorter length becomes "a".
  logic                    swap;
  logic                    e_asel;
  logic [CW-1:0]           e_alo, e_alen, e_blo, e_blen, e_kh, e_sa;
  logic [KW-1:0]           e_sb, a_addr_w, b_addr_w;
  search_mode_t            e_mode;

  // Compare step.
  logic signed [VAL_W-1:0] pa, pb, found_val;
  logic                    found;
  logic [KW-1:0]           total_w, step_alo_w, step_blo_w, step_blen_w, step_alen_w;

  assign swap   = alen_r > blen_r;
  assign e_asel = asel_r ^ swap;
  assign e_alo  = swap ? blo_r : alo_r;
  assign e_alen = swap ? blen_r : alen_r;
  assign e_blo  = swap ? alo_r : blo_r;
  assign e_blen = swap ? alen_r : blen_r;
  assign e_kh   = k_r[KW-1:1];
  assign e_sa   = (e_kh < e_alen) ? e_kh : e_alen;
  assign e_sb   = k_r - {1'b0, e_sa};

  always_comb begin
    if (e_alen == '0) begin
      e_mode   = M_TAIL;
      a_addr_w = {1'b0, e_alo};
      b_addr_w = {1'b0, e_blo} + k_r - KW'(1);
    end else if (k_r == KW'(1)) begin
      e_mode   = M_FIRST;
      a_addr_w = {1'b0, e_alo};
      b_addr_w = {1'b0, e_blo};
    end else begin
      e_mode   = M_PIVOT;
      a_addr_w = {1'b0, e_alo} + {1'b0, e_sa} - KW'(1);
      b_addr_w = {1'b0, e_blo} + e_sb - KW'(1);
    end
  end

  assign rd_addr0 = e_asel ? b_addr_w[AW-1:0] : a_addr_w[AW-1:0];
  assign rd_addr1 = e_asel ? a_addr_w[AW-1:0] : b_addr_w[AW-1:0];

  assign pa = asel_r ? rd_data1 : rd_data0;
  assign pb = asel_r ? rd_data0 : rd_data1;

  assign total_w     = {1'b0, count0} + {1'b0, count1};
  assign step_alo_w  = {1'b0, alo_r} + {1'b0, sa_r};
  assign step_alen_w = {1'b0, alen_r} - {1'b0, sa_r};
  assign step_blo_w  = {1'b0, blo_r} + sb_r;
  assign step_blen_w = {1'b0, blen_r} - sb_r;

  always_comb begin
    found     = 1'b0;
    found_val = pa;
    case (mode_r)
      M_TAIL: begin
        found     = 1'b1;
        found_val = pb;
      end
      M_FIRST: begin
        found     = 1'b1;
        found_val = (pa < pb) ? pa : pb;
      end
      M_PIVOT: begin
        found     = (pa == pb);
        found_val = pa;
      end
      default: begin
        found = 1'b1;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    mode_nxt    = mode_r;
    asel_nxt    = asel_r;
    alo_nxt     = alo_r;
    alen_nxt    = alen_r;
    blo_nxt     = blo_r;
    blen_nxt    = blen_r;
    sa_nxt      = sa_r;
    sb_nxt      = sb_r;
    k_nxt       = k_r;
    half_nxt    = half_r;
    even_nxt    = even_r;
    second_nxt  = second_r;
    upper_nxt   = upper_r;
    res.done    = 1'b0;
    res.doubled = '0;
    case (state_r)
      S_IDLE: begin
        if (go) begin
          half_nxt   = {1'b0, total_w[KW-1:1]};
          k_nxt      = {1'b0, total_w[KW-1:1]} + KW'(1);
          even_nxt   = ~total_w[0];
          second_nxt = 1'b0;
          asel_nxt   = 1'b0;
          alo_nxt    = '0;
          alen_nxt   = count0;
          blo_nxt    = '0;
          blen_nxt   = count1;
          state_nxt  = S_EVAL;
        end
      end
      S_EVAL: begin
        asel_nxt  = e_asel;
        alo_nxt   = e_alo;
        alen_nxt  = e_alen;
        blo_nxt   = e_blo;
        blen_nxt  = e_blen;
        sa_nxt    = e_sa;
        sb_nxt    = e_sb;
        mode_nxt  = e_mode;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (!found) begin
          state_nxt = S_EVAL;
          if (pa < pb) begin
            alo_nxt  = step_alo_w[CW-1:0];
            alen_nxt = step_alen_w[CW-1:0];
            k_nxt    = k_r - {1'b0, sa_r};
          end else begin
            blo_nxt  = step_blo_w[CW-1:0];
            blen_nxt = step_blen_w[CW-1:0];
            k_nxt    = k_r - sb_r;
          end
        end else if (even_r && !second_r) begin
          // Even total: now find the lower middle element.
          upper_nxt  = found_val;
          second_nxt = 1'b1;
          k_nxt      = half_r;
          asel_nxt   = 1'b0;
          alo_nxt    = '0;
          alen_nxt   = count0;
          blo_nxt    = '0;
          blen_nxt   = count1;
          state_nxt  = S_EVAL;
        end else begin
          res.done    = 1'b1;
          res.doubled = second_r ?
                        ({upper_r[VAL_W-1], upper_r} + {found_val[VAL_W-1], found_val}) :
                        {found_val, 1'b0};
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      second_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      second_r <= second_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r  <= mode_nxt;
    asel_r  <= asel_nxt;
    alo_r   <= alo_nxt;
    alen_r  <= alen_nxt;
    blo_r   <= blo_nxt;
    blen_r  <= blen_nxt;
    sa_r    <= sa_nxt;
    sb_r    <= sb_nxt;
    k_r     <= k_nxt;
    half_r  <= half_nxt;
    even_r  <= even_nxt;
    upper_r <= upper_nxt;
  end

  // A search step always alternates evaluate and compare.
  a_eval_then_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EVAL |=> state_r == S_CMP)
    else $error("evaluate step not followed by compare");

  // The remaining rank never exceeds the elements left in both ranges.
  a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EVAL |-> ({1'b0, alen_r} + {1'b0, blen_r} >= k_r) && k_r != '0)
    else $error("search rank out of range");

  // The second pass only happens for an even total.
  a_second_even: assert property (@(posedge clk) disable iff (!rst_n)
    second_r && busy |-> even_r)
    else $error("second pass on odd total");

endmodule

// ===== hdl/median_of_two_sorted_lists_core.sv =====
// Median of two ascending-sorted lists of signed 32-bit values.
// Requests enter on start/in_op/in_value and are taken at a rising edge with start
// high and busy low. An append (in_op 0 or 1) writes one element per cycle into
// that list's memory, so appends stream at one request per cycle with busy low.
// An append to a full list is dropped and raises a sticky overflow flag.
// A compute request (in_op 2) answers with exactly one result: out_valid is high
// for one cycle with out_median_doubled (twice the median, exact) and out_status
// (ok, both lists empty, or overflow seen while loading). Code 3 is ignored.
// The receiver cannot hold a result off; it must take it in the strobe cycle.
// An empty union answers in the next cycle. Otherwise each halving
// step of the k-th smallest search is an address evaluate, then a
// compare of the registered reads of the two list memories. An even
// total runs two searches. The registered strobe follows in the cycle
// after the last compare step.
// busy stays high for the whole search; a new request can be taken in the cycle
// the result is shown. After each compute the counts and overflow flag clear.
// Reset clears the counts, the flag and the control state; list contents are
// left undefined and are never read beyond the counts.
module median_of_two_sorted_lists_core #(
  parameter int LIST_DEPTH = mots_pkg::DEFAULT_LIST_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [mots_pkg::OP_W-1:0]           in_op,
  input  logic signed [mots_pkg::VAL_W-1:0]   in_value,
  output logic                                out_valid,
  output logic signed [mots_pkg::MED_W-1:0]   out_median_doubled,
  output logic [mots_pkg::STATUS_W-1:0]       out_status
);
  import mots_pkg::*;

  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);

  logic [CW-1:0]           cnt0_r, cnt0_nxt, cnt1_r, cnt1_nxt;
  logic                    ovf_r, ovf_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [MED_W-1:0] out_med_r, out_med_nxt;
  logic [STATUS_W-1:0]     out_status_r, out_status_nxt;

  logic                    accept;
  logic                    we0, we1, go;
  logic [AW-1:0]           rd_addr0, rd_addr1;
  logic signed [VAL_W-1:0] rd_data0, rd_data1;
  search_res_t             res;

  assign accept = start && !busy;

  mots_list_mem #(.LIST_DEPTH(LIST_DEPTH)) u_mem0 (
    .clk   (clk),
    .we    (we0),
    .waddr (cnt0_r[AW-1:0]),
    .wdata (in_value),
    .raddr (rd_addr0),
    .rdata (rd_data0)
  );

  mots_list_mem #(.LIST_DEPTH(LIST_DEPTH)) u_mem1 (
    .clk   (clk),
    .we    (we1),
    .waddr (cnt1_r[AW-1:0]),
    .wdata (in_value),
    .raddr (rd_addr1),
    .rdata (rd_data1)
  );

  // Writes happen only while the search is idle, so reads and writes of the
  // same entry never overlap and no forwarding is needed.
  mots_search #(.LIST_DEPTH(LIST_DEPTH)) u_search (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (go),
    .count0   (cnt0_r),
    .count1   (cnt1_r),
    .busy     (busy),
    .rd_addr0 (rd_addr0),
    .rd_addr1 (rd_addr1),
    .rd_data0 (rd_data0),
    .rd_data1 (rd_data1),
    .res      (res)
  );

  always_comb begin
    cnt0_nxt       = cnt0_r;
    cnt1_nxt       = cnt1_r;
    ovf_nxt        = ovf_r;
    out_valid_nxt  = 1'b0;
    out_med_nxt    = out_med_r;
    out_status_nxt = out_status_r;
    we0            = 1'b0;
    we1            = 1'b0;
    go             = 1'b0;
    if (res.done) begin
      // Search finished: publish and clear the loaded lists.
      out_valid_nxt  = 1'b1;
      out_med_nxt    = res.doubled;
      out_status_nxt = ovf_r ? ST_OVERFLOW : ST_OK;
      cnt0_nxt       = '0;
      cnt1_nxt       = '0;
      ovf_nxt        = 1'b0;
    end else if (accept) begin
      case (op_t'(in_op))
        OP_APPEND_FIRST: begin
          if (cnt0_r < DEPTH_C) begin
            we0      = 1'b1;
            cnt0_nxt = cnt0_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end
        OP_APPEND_SECOND: begin
          if (cnt1_r < DEPTH_C) begin
            we1      = 1'b1;
            cnt1_nxt = cnt1_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end
        OP_MEDIAN: begin
          if (cnt0_r == '0 && cnt1_r == '0) begin
            // Nothing loaded: answer at once with the empty status.
            out_valid_nxt  = 1'b1;
            out_med_nxt    = '0;
            out_status_nxt = ST_EMPTY;
            ovf_nxt        = 1'b0;
          end else begin
            go = 1'b1;
          end
        end
        default: begin
          // Unused code: no effect.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt0_r      <= '0;
      cnt1_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt0_r      <= cnt0_nxt;
      cnt1_r      <= cnt1_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_med_r    <= out_med_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_median_doubled = out_med_r;
  assign out_status         = out_status_r;

  // The lists must not change under a running search.
  a_counts_hold: assert property (@(posedge clk) disable iff (!rst_n)
    busy && !res.done |=> $stable(cnt0_r) && $stable(cnt1_r))
    else $error("list counts changed during search");

  // A nonempty compute request always starts the search.
  a_compute_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_op == OP_MEDIAN && (cnt0_r != '0 || cnt1_r != '0) |=> busy)
    else $error("compute request did not start a search");

  // A result is only shown once the search has returned to idle.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !busy)
    else $error("result shown while search still running");

  // Counts never pass the capacity.
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt0_r <= DEPTH_C && cnt1_r <= DEPTH_C)
    else $error("list count exceeds capacity");

endmodule
